// ===== rtl/mi3_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse pipeline.
package mi3_pkg;

    localparam int IN_FRAC_BITS  = 8;
    localparam int OUT_FRAC_BITS = 16;
    // total scale applied to a cofactor before the divide
    localparam int SHIFT_BITS    = IN_FRAC_BITS + OUT_FRAC_BITS;
    // quotient bits kept; anything at or above 2^QBITS saturates anyway
    localparam int QBITS         = 33;
    localparam int PRE_BITS      = QBITS - SHIFT_BITS;
    localparam int RESCALE_BITS  = OUT_FRAC_BITS - IN_FRAC_BITS;
    localparam int LANE_LAT      = QBITS + 2;

    localparam int ENT_W = 16;
    localparam int COF_W = 32;   // cofactor magnitude
    localparam int DET_W = 48;   // determinant magnitude
    localparam int RES_W = 32;

    typedef struct packed {
        logic signed [ENT_W-1:0] m00;
        logic signed [ENT_W-1:0] m01;
        logic signed [ENT_W-1:0] m02;
        logic signed [ENT_W-1:0] m10;
        logic signed [ENT_W-1:0] m11;
        logic signed [ENT_W-1:0] m12;
        logic signed [ENT_W-1:0] m20;
        logic signed [ENT_W-1:0] m21;
        logic signed [ENT_W-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [RES_W-1:0] r00;
        logic signed [RES_W-1:0] r01;
        logic signed [RES_W-1:0] r02;
        logic signed [RES_W-1:0] r10;
        logic signed [RES_W-1:0] r11;
        logic signed [RES_W-1:0] r12;
        logic signed [RES_W-1:0] r20;
        logic signed [RES_W-1:0] r21;
        logic signed [RES_W-1:0] r22;
        logic                    singular;
    } inv_t;

    // cofactor front end to divider lanes
    typedef struct packed {
        logic                        valid;
        logic                        sing;
        logic                        dneg;
        logic [DET_W-1:0]            detm;
        logic [8:0]                  cneg;
        logic [8:0][COF_W-1:0]       cofm;
        logic [8:0][ENT_W-1:0]       ent;
    } cof_bus_t;

    typedef struct packed {
        logic              ovf;
        logic              neg;
        logic              sing;
        logic [QBITS:0]    mag;
        logic [ENT_W-1:0]  ent;
    } lane_t;

endpackage

// ===== rtl/mi3_cofactor.sv =====
// Cofactor and determinant stages: products, cofactors, det terms, det sum.
module mi3_cofactor (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid,
    input  mi3_pkg::mat_t    mat,
    output mi3_pkg::cof_bus_t bus
);
    import mi3_pkg::*;

    logic signed [ENT_W-1:0] a_in [9];
    logic signed [ENT_W-1:0] a1_reg [9];
    logic signed [ENT_W-1:0] a2_reg [9];
    logic signed [ENT_W-1:0] a3_reg [9];
    logic signed [31:0]      p_reg  [18];
    logic signed [32:0]      cof_reg [9];
    logic signed [32:0]      cof3_reg [9];
    logic signed [48:0]      t_reg  [3];
    logic [3:0]              vld_reg;
    cof_bus_t                bus_reg;
    cof_bus_t                bus_next;
    logic signed [49:0]      det;

    assign a_in[0] = mat.m00;
    assign a_in[1] = mat.m01;
    assign a_in[2] = mat.m02;
    assign a_in[3] = mat.m10;
    assign a_in[4] = mat.m11;
    assign a_in[5] = mat.m12;
    assign a_in[6] = mat.m20;
    assign a_in[7] = mat.m21;
    assign a_in[8] = mat.m22;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= a_in;
            a2_reg <= a1_reg;
            a3_reg <= a2_reg;
            // cofactor pairs, plus term then minus term
            p_reg[0]  <= a_in[4] * a_in[8];  p_reg[1]  <= a_in[5] * a_in[7];
            p_reg[2]  <= a_in[2] * a_in[7];  p_reg[3]  <= a_in[1] * a_in[8];
            p_reg[4]  <= a_in[1] * a_in[5];  p_reg[5]  <= a_in[2] * a_in[4];
            p_reg[6]  <= a_in[5] * a_in[6];  p_reg[7]  <= a_in[3] * a_in[8];
            p_reg[8]  <= a_in[0] * a_in[8];  p_reg[9]  <= a_in[2] * a_in[6];
            p_reg[10] <= a_in[2] * a_in[3];  p_reg[11] <= a_in[0] * a_in[5];
            p_reg[12] <= a_in[3] * a_in[7];  p_reg[13] <= a_in[4] * a_in[6];
            p_reg[14] <= a_in[1] * a_in[6];  p_reg[15] <= a_in[0] * a_in[7];
            p_reg[16] <= a_in[0] * a_in[4];  p_reg[17] <= a_in[1] * a_in[3];
            for (int i = 0; i < 9; i++)
            begin
                cof_reg[i] <= 33'(p_reg[2*i]) - 33'(p_reg[2*i+1]);
            end
            cof3_reg <= cof_reg;
            t_reg[0] <= a2_reg[0] * cof_reg[0];
            t_reg[1] <= a2_reg[1] * cof_reg[3];
            t_reg[2] <= a2_reg[2] * cof_reg[6];
            bus_reg  <= bus_next;
        end
    end

    always_comb
    begin
        det = 50'(t_reg[0]) + 50'(t_reg[1]) + 50'(t_reg[2]);
        bus_next.valid = vld_reg[2];
        bus_next.sing  = (det == '0);
        bus_next.dneg  = det[49];
        bus_next.detm  = det[49] ? DET_W'(-det) : DET_W'(det);
        for (int i = 0; i < 9; i++)
        begin
            bus_next.cneg[i] = cof3_reg[i][32];
            bus_next.cofm[i] = cof3_reg[i][32] ? COF_W'(-cof3_reg[i]) : COF_W'(cof3_reg[i]);
            bus_next.ent[i]  = a3_reg[i];
        end
    end

    always_comb
    begin
        bus       = bus_reg;
        bus.valid = vld_reg[3];
    end

endmodule

// ===== rtl/mi3_div_lane.sv =====
// One restoring divider lane: a bit per stage, then round to nearest.
module mi3_div_lane (
    input  logic                       clk,
    input  logic                       en,
    input  logic [mi3_pkg::COF_W-1:0]  num,
    input  logic [mi3_pkg::DET_W-1:0]  den,
    input  logic                       neg,
    input  logic                       sing,
    input  logic [mi3_pkg::ENT_W-1:0]  ent,
    output mi3_pkg::lane_t             lane
);
    import mi3_pkg::*;

    logic [DET_W-1:0] rem_reg  [QBITS+1];
    logic [DET_W-1:0] rem_next [QBITS];
    logic [DET_W-1:0] den_reg  [QBITS+1];
    logic [QBITS-1:0] qd_reg   [QBITS+1];
    logic [QBITS-1:0] qd_next  [QBITS];
    logic             ovf_reg  [QBITS+1];
    logic             neg_reg  [QBITS+1];
    logic             sing_reg [QBITS+1];
    logic [ENT_W-1:0] ent_reg  [QBITS+1];
    lane_t            lane_reg;
    lane_t            lane_next;

    always_comb
    begin
        logic [DET_W:0]   sh;
        logic [DET_W+1:0] diff;
        for (int k = 0; k < QBITS; k++)
        begin
            sh   = {rem_reg[k], qd_reg[k][QBITS-1]};
            diff = {1'b0, sh} - {2'b0, den_reg[k]};
            if (!diff[DET_W+1])
            begin
                rem_next[k] = diff[DET_W-1:0];
            end
            else
            begin
                rem_next[k] = sh[DET_W-1:0];
            end
            qd_next[k] = {qd_reg[k][QBITS-2:0], ~diff[DET_W+1]};
        end
    end

    always_comb
    begin
        logic rnd;
        rnd             = ({rem_reg[QBITS], 1'b0} >= {1'b0, den_reg[QBITS]});
        lane_next.ovf   = ovf_reg[QBITS];
        lane_next.neg   = neg_reg[QBITS];
        lane_next.sing  = sing_reg[QBITS];
        lane_next.ent   = ent_reg[QBITS];
        lane_next.mag   = (QBITS+1)'(qd_reg[QBITS]) + (QBITS+1)'(rnd);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient >= 2^QBITS saturates; the start remainder is then below den
            rem_reg[0]  <= DET_W'(num >> PRE_BITS);
            qd_reg[0]   <= {num[PRE_BITS-1:0], {SHIFT_BITS{1'b0}}};
            den_reg[0]  <= den;
            ovf_reg[0]  <= ((DET_W+PRE_BITS)'(num) >= {den, {PRE_BITS{1'b0}}});
            neg_reg[0]  <= neg;
            sing_reg[0] <= sing;
            ent_reg[0]  <= ent;
            for (int k = 0; k < QBITS; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                qd_reg[k+1]   <= qd_next[k];
                den_reg[k+1]  <= den_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                sing_reg[k+1] <= sing_reg[k];
                ent_reg[k+1]  <= ent_reg[k];
            end
            lane_reg <= lane_next;
        end
    end

    assign lane = lane_reg;

endmodule

// ===== rtl/matrix3x3_inverse.sv =====
// Top level: 3x3 matrix inverse by adjugate, fully pipelined.
//
//  channel | ports                       | word
//  --------+-----------------------------+------------------------------
//  matrix  | mat_valid mat_ready mat     | nine Q8.8 entries
//  inverse | inv_valid inv_ready inv     | nine Q16.16 entries, singular
//
// One matrix enters per cycle while mat_ready is high. The pipeline has four
// cofactor and determinant stages, 35 divider stages (33 quotient bits at one bit per
// stage, plus setup and rounding) and the saturating output register.
// Reset clears only the valid bits. When the output word is held, every
// stage holds with it and mat_ready drops; nothing is dropped or repeated.
module matrix3x3_inverse (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          mat_valid,
    output logic          mat_ready,
    input  mi3_pkg::mat_t mat,
    output logic          inv_valid,
    input  logic          inv_ready,
    output mi3_pkg::inv_t inv
);
    import mi3_pkg::*;

    logic                    en;
    cof_bus_t                bus;
    lane_t                   lane [9];
    logic [LANE_LAT-1:0]     vld_reg;
    logic signed [RES_W-1:0] res [9];
    logic                    sing;
    inv_t                    inv_reg;
    inv_t                    inv_next;
    logic                    inv_valid_reg;

    assign en        = !inv_valid_reg || inv_ready;
    assign mat_ready = en;

    mi3_cofactor u_cof (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .valid (mat_valid),
        .mat   (mat),
        .bus   (bus)
    );

    for (genvar i = 0; i < 9; i++)
    begin : g_lane
        mi3_div_lane u_lane (
            .clk  (clk),
            .en   (en),
            .num  (bus.cofm[i]),
            .den  (bus.detm),
            .neg  (bus.cneg[i] ^ bus.dneg),
            .sing (bus.sing),
            .ent  (bus.ent[i]),
            .lane (lane[i])
        );
    end

    always_comb
    begin
        sing = lane[0].sing;
        for (int i = 0; i < 9; i++)
        begin
            if (lane[i].sing)
            begin
                res[i] = RES_W'({{(RES_W-ENT_W){lane[i].ent[ENT_W-1]}}, lane[i].ent})
                         <<< RESCALE_BITS;
            end
            else if (lane[i].neg)
            begin
                if (lane[i].ovf || lane[i].mag >= (QBITS+1)'(34'h080000000))
                begin
                    res[i] = {1'b1, {(RES_W-1){1'b0}}};
                end
                else
                begin
                    res[i] = RES_W'(-lane[i].mag);
                end
            end
            else if (lane[i].ovf || lane[i].mag > (QBITS+1)'(34'h07FFFFFFF))
            begin
                res[i] = {1'b0, {(RES_W-1){1'b1}}};
            end
            else
            begin
                res[i] = RES_W'(lane[i].mag);
            end
        end
        inv_next.r00      = res[0];
        inv_next.r01      = res[1];
        inv_next.r02      = res[2];
        inv_next.r10      = res[3];
        inv_next.r11      = res[4];
        inv_next.r12      = res[5];
        inv_next.r20      = res[6];
        inv_next.r21      = res[7];
        inv_next.r22      = res[8];
        inv_next.singular = sing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            inv_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[LANE_LAT-2:0], bus.valid};
            inv_valid_reg <= vld_reg[LANE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg <= inv_next;
        end
    end

    assign inv_valid = inv_valid_reg;
    assign inv       = inv_reg;

`ifndef SYNTH
    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && !inv_ready |=> $stable(vld_reg))
        else $error("pipeline moved while output word was held");

    a_sing_rescaled: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv.singular |->
            inv.r00[RESCALE_BITS-1:0] == '0 && inv.r11[RESCALE_BITS-1:0] == '0 &&
            inv.r22[RESCALE_BITS-1:0] == '0)
        else $error("singular word not a rescaled input");

    a_ready_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
        !inv_valid |-> mat_ready)
        else $error("input stalled with empty output register");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Testbench for matrix3x3_inverse: random and directed matrices against a local predictor.
module tb_top;
    import mi3_pkg::*;

    logic  clk;
    logic  rst_n;
    logic  mat_valid;
    logic  mat_ready;
    mat_t  mat;
    logic  inv_valid;
    logic  inv_ready;
    inv_t  inv;

    mat_t  pending_mats[$];
    inv_t  expected_invs[$];
    int    errors;
    longint cycles = 0;
    bit    stim_done;
    int    src_gap;
    int    sink_gap;
    // acceptance seen at the last rising edge
    logic  mat_ready_q;

    matrix3x3_inverse DUT (
        .clk(clk), .rst_n(rst_n),
        .mat_valid(mat_valid), .mat_ready(mat_ready), .mat(mat),
        .inv_valid(inv_valid), .inv_ready(inv_ready), .inv(inv)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // saturate sign/magnitude to 32-bit signed
    function automatic logic [31:0] clamp32(bit neg, logic [63:0] mag);
        if (neg)
        begin
            if (mag >= 64'h8000_0000) return 32'h8000_0000;
            return 32'(-mag);
        end
        if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    // round(num * 2^SHIFT_BITS / den), ties away from zero
    function automatic logic [63:0] scaled_quot(logic [63:0] num, logic [63:0] den);
        logic [127:0] n;
        logic [127:0] q;
        logic [127:0] r;
        n = {64'd0, num} << SHIFT_BITS;
        q = n / den;
        r = n % den;
        if (2 * r >= den) q = q + 1;
        if (q > 128'h1_0000_0000) return 64'h1_0000_0000;
        return q[63:0];
    endfunction

    function automatic inv_t predict_inverse(mat_t m);
        longint a[9];
        longint cof[9];
        longint det;
        logic [31:0] res[9];
        bit neg;
        logic [63:0] q;
        logic [63:0] dm;
        inv_t o;
        a = '{m.m00, m.m01, m.m02, m.m10, m.m11, m.m12, m.m20, m.m21, m.m22};
        cof[0] = a[4]*a[8] - a[5]*a[7];
        cof[1] = a[2]*a[7] - a[1]*a[8];
        cof[2] = a[1]*a[5] - a[2]*a[4];
        cof[3] = a[5]*a[6] - a[3]*a[8];
        cof[4] = a[0]*a[8] - a[2]*a[6];
        cof[5] = a[2]*a[3] - a[0]*a[5];
        cof[6] = a[3]*a[7] - a[4]*a[6];
        cof[7] = a[1]*a[6] - a[0]*a[7];
        cof[8] = a[0]*a[4] - a[1]*a[3];
        det = a[0]*cof[0] + a[1]*cof[3] + a[2]*cof[6];
        if (det == 0)
        begin
            for (int i = 0; i < 9; i++)
                res[i] = clamp32(a[i] < 0, (a[i] < 0 ? -a[i] : a[i]) << RESCALE_BITS);
        end
        else
        begin
            dm = det < 0 ? -det : det;
            for (int i = 0; i < 9; i++)
            begin
                q = scaled_quot(cof[i] < 0 ? -cof[i] : cof[i], dm);
                neg = ((cof[i] < 0) != (det < 0)) && (q != 0);
                res[i] = clamp32(neg, q);
            end
        end
        o = '{res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], res[8],
              det == 0};
        return o;
    endfunction

    function automatic logic [15:0] rand_entry();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 1024)) - 512);
            3: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 8'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic mat_t rand_mat();
        mat_t m;
        m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
             rand_entry(), rand_entry(), rand_entry(), rand_entry()};
        // some singular: copy or negate a row, or zero a column
        case ($urandom_range(0, 9))
            0: {m.m20, m.m21, m.m22} = {m.m00, m.m01, m.m02};
            1: {m.m10, m.m11, m.m12} = {-m.m00, -m.m01, -m.m02};
            2: {m.m02, m.m12, m.m22} = 48'd0;
            default: ;
        endcase
        return m;
    endfunction

    initial
    begin
        errors = 0;
        stim_done = 0;
        // identity, unit scale
        pending_mats.push_back('{16'h0100, 0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100});
        pending_mats.push_back('{16'h0001, 0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001});
        pending_mats.push_back('{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000});
        pending_mats.push_back('{16'h7FFF, 0, 0, 0, 16'h7FFF, 0, 0, 0, 16'h7FFF});
        pending_mats.push_back('{16'h7FFF, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h0001});
        pending_mats.push_back('0);
        pending_mats.push_back({9{16'h8000}});
        pending_mats.push_back({9{16'h7FFF}});
        pending_mats.push_back({9{16'hFFFF}});
        pending_mats.push_back('{16'h7FFF, 16'h8000, 16'h0001, 16'h0200, 16'hFF00,
                                 16'h0300, 16'h1234, 16'hEDCB, 16'h0100});
        pending_mats.push_back('{0, 16'h0100, 0, 0, 0, 16'h0100, 16'h0100, 0, 0});
        pending_mats.push_back('{16'h0300, 0, 0, 0, 16'h0300, 0, 0, 0, 16'h0300});
        pending_mats.push_back('{16'h0001, 16'h0001, 0, 16'h0001, 16'h0002, 0, 0, 0,
                                 16'h0001});
        pending_mats.push_back('{16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500,
                                 16'h0600, 16'h0700, 16'h0800, 16'h0900});
        for (int i = 0; i < 1040; i++)
            pending_mats.push_back(rand_mat());
        stim_done = 1;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_valid <= 1'b0;
            mat <= '0;
            src_gap <= 0;
        end
        else if (!mat_valid || mat_ready_q)
        begin
            if (src_gap > 0 || pending_mats.size() == 0)
            begin
                mat_valid <= 1'b0;
                if (src_gap > 0) src_gap <= src_gap - 1;
            end
            else
            begin
                mat <= pending_mats.pop_front();
                mat_valid <= 1'b1;
                src_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mat_ready_q <= 1'b0;
        else
        begin
            mat_ready_q <= mat_valid && mat_ready;
            if (mat_valid && mat_ready)
                expected_invs.push_back(predict_inverse(mat));
        end
    end

    // sink readiness
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_ready <= 1'b0;
            sink_gap <= 0;
        end
        else if (sink_gap > 0)
        begin
            inv_ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end
        else
        begin
            inv_ready <= 1'b1;
            sink_gap <= pick_gap();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        inv_t exp_w;
        if (rst_n && inv_valid && inv_ready)
        begin
            if (expected_invs.size() == 0)
            begin
                $display("%0t unexpected word: exp none act %h", $time, inv);
                errors++;
            end
            else
            begin
                exp_w = expected_invs.pop_front();
                if (exp_w !== inv)
                begin
                    $display("%0t mismatch: exp %h act %h", $time, exp_w, inv);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done && pending_mats.size() == 0 && !mat_valid && expected_invs.size() == 0);
        repeat (60) @(posedge clk);
        if (errors == 0 && expected_invs.size() == 0)
            $display("PASS matrix3x3_inverse");
        else
            $display("FAIL matrix3x3_inverse");
        $finish;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("FAIL matrix3x3_inverse");
            $finish;
        end
    end

endmodule
